// ===== rtl/cgbe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cgbe_pkg;

  // Operation codes of an input beat.
  typedef enum logic [1:0] {
    FN_LOAD   = 2'd0,
    FN_DESC   = 2'd1,
    FN_RENDER = 2'd2,
    FN_READ   = 2'd3
  } func_e;

  // One classified command as it travels through the queue.
  typedef struct packed {
    func_e       func;
    logic [7:0]  glyph_index;
    logic [13:0] byte_addr;
    logic [7:0]  byte_value;
    logic [7:0]  glyph_width;
    logic [7:0]  glyph_height;
    logic [13:0] bitmap_offset;
    logic        map_select;
    logic [7:0]  map_row;
    logic [2:0]  map_word;
  } cmd_t;

  // Status of the execution side as seen by the front.
  typedef struct packed {
    logic take;
    logic clearing;
  } back_stat_t;

  // Reduces v modulo m by eight conditional subtractions of shifted m.
  // Valid while v is below 256 times m.
  function automatic logic [31:0] reduce_mod(logic [31:0] v, logic [31:0] m);
    logic [31:0] r;
    r = v;
    for (int j = 7; j >= 0; j--) begin
      if (r >= (m << j)) begin
        r = r - (m << j);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cgbe_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cgbe_front #(
  parameter int STORE_BYTES = 16384,
  parameter int GLYPH_COUNT = 256
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start,
  output logic              busy,
  input  cgbe_pkg::cmd_t    cmd_i,
  input  cgbe_pkg::back_stat_t stat_i,
  output logic              cmd_valid_o,
  output cgbe_pkg::cmd_t    cmd_o
);
  import cgbe_pkg::*;

  cmd_t       fifo_q [2];
  cmd_t       cls;
  logic       wptr_q, rptr_q;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  // Wrap the glyph index and the store address on entry.
  always_comb begin
    cls             = cmd_i;
    cls.glyph_index = 8'(reduce_mod({24'b0, cmd_i.glyph_index}, 32'(GLYPH_COUNT)));
    cls.byte_addr   = 14'(reduce_mod({18'b0, cmd_i.byte_addr}, 32'(STORE_BYTES)));
  end

  // Handshake of the two-entry queue.
  assign busy        = (count_q == 2'd2) || stat_i.clearing;
  assign push        = start && !busy;
  assign cmd_valid_o = (count_q != 2'd0);
  assign pop         = cmd_valid_o && stat_i.take;
  assign cmd_o       = fifo_q[rptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push) wptr_q <= !wptr_q;
      if (pop)  rptr_q <= !rptr_q;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= cls;
    end
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== rtl/cgbe_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cgbe_back #(
  parameter int MAP_SIZE    = 160,
  parameter int STORE_BYTES = 16384,
  parameter int GLYPH_COUNT = 256
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire                  cfg_wdata_i,
  input  wire                  cmd_valid_i,
  input  cgbe_pkg::cmd_t       cmd_i,
  output cgbe_pkg::back_stat_t stat_o,
  output logic                 result_valid_o,
  output logic [31:0]          read_data_o,
  output logic                 render_done_o
);
  import cgbe_pkg::*;

  localparam int RW     = (MAP_SIZE + 31) / 32;
  localparam int MDEPTH = 2 * MAP_SIZE * RW;
  localparam int MAW    = $clog2(MDEPTH);
  localparam int CW     = $clog2(MAP_SIZE + 1);
  localparam int SA     = $clog2(STORE_BYTES);
  localparam int GA     = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam int WHW    = $clog2(MAP_SIZE * MAP_SIZE + 1);
  localparam int ACW    = WHW + SA;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_DESC  = 7'b0000100,
    S_SETUP = 7'b0001000,
    S_WRAP  = 7'b0010000,
    S_WALK  = 7'b0100000,
    S_FLUSH = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Memories.
  logic [7:0]  gstore [STORE_BYTES];
  logic [29:0] desc_mem [GLYPH_COUNT];
  logic [31:0] map_mem [MDEPTH];

  logic [7:0]  g_rdata_q;
  logic [29:0] desc_rdata_q;
  logic [31:0] map_rdata_q;

  logic           rot_q;
  logic           pop;
  logic [MAW-1:0] clr_q, clr_d;
  logic           sel_q, sel_d;

  // Render setup registers.
  logic [CW-1:0]  ox_q, oy_q, oxe_q, oye_q;
  logic [CW-1:0]  ox_d, oy_d, oxe_d, oye_d;
  logic [WHW-1:0] wh_q, wh_d;
  logic [SA-1:0]  offr_q, offr_d;
  logic [ACW-1:0] acc_q, acc_d;
  logic [2:0]     k_q, k_d;
  logic [CW-1:0]  row_q, row_d, col_q, col_d;

  // Second walk stage.
  logic           b_valid_q, b_in_q;
  logic [2:0]     b_k_q;
  logic [CW-1:0]  b_row_q, b_col_q;
  logic [31:0]    buf_q, buf_d;

  logic res_valid_d, res_done_d, res_rd_d;
  logic res_valid_q, res_done_q, res_rd_q;

  // Combinational helpers.
  logic [CW-1:0]  wc, hc, srow, scol;
  logic           inbox;
  logic [WHW-1:0] whm1;
  logic [15:0]    colx;
  logic [4:0]     bidx;
  logic           bbit, map_we, rd_ok;
  logic [MAW-1:0] map_wa, map_ra;
  logic [31:0]    map_wd;

  assign pop           = cmd_valid_i && (state_q == S_IDLE);
  assign stat_o.take   = (state_q == S_IDLE);
  assign stat_o.clearing = (state_q == S_CLEAR);

  // Descriptor clamp of width and height to the map size.
  always_comb begin
    if (16'(desc_rdata_q[29:22]) > 16'(MAP_SIZE)) wc = CW'(MAP_SIZE);
    else wc = CW'(desc_rdata_q[29:22]);
    if (16'(desc_rdata_q[21:14]) > 16'(MAP_SIZE)) hc = CW'(MAP_SIZE);
    else hc = CW'(desc_rdata_q[21:14]);
  end

  // Source pixel of the current destination pixel and its box test.
  always_comb begin
    srow  = rot_q ? CW'(MAP_SIZE - 1) - row_q : row_q;
    scol  = rot_q ? CW'(MAP_SIZE - 1) - col_q : col_q;
    inbox = (srow >= oy_q) && (srow < oye_q) && (scol >= ox_q) && (scol < oxe_q);
    whm1  = wh_q - WHW'(1);
  end

  // Read address of a map word and its range check.
  always_comb begin
    rd_ok  = (16'(cmd_i.map_row) < 16'(MAP_SIZE)) && (16'(cmd_i.map_word) < 16'(RW));
    map_ra = '0;
    if (rd_ok) begin
      map_ra = MAW'((32'(cmd_i.map_select) * MAP_SIZE + 32'(cmd_i.map_row)) * RW
                    + 32'(cmd_i.map_word));
    end
  end

  // Word assembly in the second walk stage.
  always_comb begin
    colx  = 16'(b_col_q);
    bidx  = colx[4:0];
    bbit  = b_in_q && g_rdata_q[3'd7 - b_k_q];
    buf_d = ((bidx == 5'd0) ? 32'd0 : buf_q) | (32'(bbit) << bidx);
  end

  // Map write port: clearing pass or render words.
  always_comb begin
    map_we = 1'b0;
    map_wa = clr_q;
    map_wd = '0;
    if (state_q == S_CLEAR) begin
      map_we = 1'b1;
    end else if (b_valid_q && ((bidx == 5'd31) || (b_col_q == CW'(MAP_SIZE - 1)))) begin
      map_we = 1'b1;
      map_wa = MAW'((32'(sel_q) * MAP_SIZE + 32'(b_row_q)) * RW + 32'(colx >> 5));
      map_wd = buf_d;
    end
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    sel_d       = sel_q;
    ox_d        = ox_q;
    oy_d        = oy_q;
    oxe_d       = oxe_q;
    oye_d       = oye_q;
    wh_d        = wh_q;
    offr_d      = offr_q;
    acc_d       = acc_q;
    k_d         = k_q;
    row_d       = row_q;
    col_d       = col_q;
    res_valid_d = 1'b0;
    res_done_d  = 1'b0;
    res_rd_d    = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + MAW'(1);
        if (clr_q == MAW'(MDEPTH - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (pop) begin
          unique case (cmd_i.func)
            FN_RENDER: begin
              sel_d   = cmd_i.map_select;
              state_d = S_DESC;
            end
            FN_READ: begin
              res_valid_d = 1'b1;
              res_rd_d    = rd_ok;
            end
            default: res_valid_d = 1'b1;
          endcase
        end
      end
      S_DESC: begin
        ox_d   = (CW'(MAP_SIZE) - wc) >> 1;
        oy_d   = (CW'(MAP_SIZE) - hc) >> 1;
        oxe_d  = ((CW'(MAP_SIZE) - wc) >> 1) + wc;
        oye_d  = ((CW'(MAP_SIZE) - hc) >> 1) + hc;
        wh_d   = WHW'(wc * hc);
        offr_d = SA'(reduce_mod(32'(desc_rdata_q[13:0]), 32'(STORE_BYTES)));
        state_d = S_SETUP;
      end
      S_SETUP: begin
        acc_d   = ACW'(offr_q) + (rot_q ? ACW'(whm1 >> 3) : ACW'(0));
        k_d     = rot_q ? whm1[2:0] : 3'd0;
        state_d = S_WRAP;
      end
      S_WRAP: begin
        if (acc_q >= ACW'(STORE_BYTES)) begin
          acc_d = acc_q - ACW'(STORE_BYTES);
        end else begin
          row_d   = '0;
          col_d   = '0;
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        // Step the bit stream forward, or backward when rotated.
        if (inbox) begin
          if (!rot_q) begin
            k_d = k_q + 3'd1;
            if (k_q == 3'd7) begin
              acc_d = (acc_q == ACW'(STORE_BYTES - 1)) ? ACW'(0) : acc_q + ACW'(1);
            end
          end else begin
            k_d = k_q - 3'd1;
            if (k_q == 3'd0) begin
              acc_d = (acc_q == ACW'(0)) ? ACW'(STORE_BYTES - 1) : acc_q - ACW'(1);
            end
          end
        end
        if (col_q == CW'(MAP_SIZE - 1)) begin
          col_d = '0;
          row_d = row_q + CW'(1);
          if (row_q == CW'(MAP_SIZE - 1)) state_d = S_FLUSH;
        end else begin
          col_d = col_q + CW'(1);
        end
      end
      S_FLUSH: begin
        res_valid_d = 1'b1;
        res_done_d  = 1'b1;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      rot_q       <= 1'b0;
      b_valid_q   <= 1'b0;
      res_valid_q <= 1'b0;
      res_done_q  <= 1'b0;
      res_rd_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      b_valid_q   <= (state_q == S_WALK);
      res_valid_q <= res_valid_d;
      res_done_q  <= res_done_d;
      res_rd_q    <= res_rd_d;
      if (cfg_we_i) rot_q <= cfg_wdata_i;
    end
  end

  // Payload registers of the sequencer and the walk.
  always_ff @(posedge clk_i) begin
    sel_q   <= sel_d;
    ox_q    <= ox_d;
    oy_q    <= oy_d;
    oxe_q   <= oxe_d;
    oye_q   <= oye_d;
    wh_q    <= wh_d;
    offr_q  <= offr_d;
    acc_q   <= acc_d;
    k_q     <= k_d;
    row_q   <= row_d;
    col_q   <= col_d;
    b_in_q  <= inbox;
    b_k_q   <= k_q;
    b_row_q <= row_q;
    b_col_q <= col_q;
    if (b_valid_q) buf_q <= buf_d;
  end

  // Glyph store.
  always_ff @(posedge clk_i) begin
    if (pop && (cmd_i.func == FN_LOAD)) begin
      gstore[SA'(cmd_i.byte_addr)] <= cmd_i.byte_value;
    end
    g_rdata_q <= gstore[acc_q[SA-1:0]];
  end

  // Descriptor table.
  always_ff @(posedge clk_i) begin
    if (pop && (cmd_i.func == FN_DESC)) begin
      desc_mem[GA'(cmd_i.glyph_index)] <=
        {cmd_i.glyph_width, cmd_i.glyph_height, cmd_i.bitmap_offset};
    end
    desc_rdata_q <= desc_mem[GA'(cmd_i.glyph_index)];
  end

  // Pixel maps.
  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    map_rdata_q <= map_mem[map_ra];
  end

  assign result_valid_o = res_valid_q;
  assign render_done_o  = res_done_q;
  assign read_data_o    = res_rd_q ? map_rdata_q : 32'd0;

  a_done_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_done_q |-> res_valid_q) else $error("done without result beat");

  a_stage_b : assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q |-> $past(state_q == S_WALK)) else $error("walk stage out of step");

  a_end_render : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(b_valid_q) |-> (res_valid_q && res_done_q))
    else $error("render ended without done beat");

endmodule

`default_nettype wire

// ===== rtl/centered_glyph_bitmap_expander_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Glyph expander with two one-bit pixel maps. After reset the block clears both maps,
// one 32-pixel word per cycle, 2*MAP_SIZE*ceil(MAP_SIZE/32) words in all (1600 at the
// default size), and holds busy high meanwhile. Commands enter through a two-entry
// queue: glyph byte loads, descriptor writes and map word reads are handled without
// leaving the idle state and give their result beat in the cycle after the execution
// side takes them. A render passes the descriptor, setup and wrap states, then walks
// the whole selected map one pixel per cycle through the glyph store read port. Every
// command gives exactly one result beat, strobed by result_valid_o for one cycle; the
// receiver cannot stall it. The rotation register may be written only while idle.
module centered_glyph_bitmap_expander_unit #(
  parameter int MAP_SIZE    = 160,
  parameter int STORE_BYTES = 16384,
  parameter int GLYPH_COUNT = 256
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start,
  output logic        busy,
  input  wire         cfg_we_i,
  input  wire         cfg_wdata_i,
  input  wire  [1:0]  func_i,
  input  wire  [7:0]  glyph_index_i,
  input  wire  [13:0] byte_addr_i,
  input  wire  [7:0]  byte_value_i,
  input  wire  [7:0]  glyph_width_i,
  input  wire  [7:0]  glyph_height_i,
  input  wire  [13:0] bitmap_offset_i,
  input  wire         map_select_i,
  input  wire  [7:0]  map_row_i,
  input  wire  [2:0]  map_word_i,
  output logic        result_valid_o,
  output logic [31:0] read_data_o,
  output logic        render_done_o
);
  import cgbe_pkg::*;

  cmd_t       in_cmd, q_cmd;
  logic       q_valid;
  back_stat_t stat;

  // Gather the input fields into one command.
  always_comb begin
    in_cmd.func          = func_e'(func_i);
    in_cmd.glyph_index   = glyph_index_i;
    in_cmd.byte_addr     = byte_addr_i;
    in_cmd.byte_value    = byte_value_i;
    in_cmd.glyph_width   = glyph_width_i;
    in_cmd.glyph_height  = glyph_height_i;
    in_cmd.bitmap_offset = bitmap_offset_i;
    in_cmd.map_select    = map_select_i;
    in_cmd.map_row       = map_row_i;
    in_cmd.map_word      = map_word_i;
  end

  cgbe_front #(
    .STORE_BYTES (STORE_BYTES),
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (in_cmd),
    .stat_i      (stat),
    .cmd_valid_o (q_valid),
    .cmd_o       (q_cmd)
  );

  cgbe_back #(
    .MAP_SIZE    (MAP_SIZE),
    .STORE_BYTES (STORE_BYTES),
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_valid_i    (q_valid),
    .cmd_i          (q_cmd),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .read_data_o    (read_data_o),
    .render_done_o  (render_done_o)
  );

endmodule

`default_nettype wire
